### src/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg: shared types and constants for the rate-monotonic scheduler
// Task table sizing, event codes, controller states and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

    localparam int MAX_TASKS = 8;
    localparam int TIME_BITS = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int SCAN_W    = $clog2(MAX_TASKS + 1);
    localparam int CU_W      = $clog2(TIME_BITS);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        EV_IDLE     = 3'd0,
        EV_RUNNING  = 3'd1,
        EV_PREEMPT  = 3'd2,
        EV_DONE     = 3'd3,
        EV_LATE     = 3'd4,
        EV_LOAD     = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_CATCHUP,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // write the addressed slot
        logic scan_clr;    // start best-ready scan
        logic scan_step;   // examine one slot
        logic decide;      // perform tick decision and work
        logic catchup;     // one catch-up remainder step
        logic out_load;    // capture result
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic need_catchup;
    } t_stat;

endpackage

`default_nettype wire

### src/rms_ctrl.sv
// ----------------------------------------------------------------------------
// rms_ctrl: scheduler controller
// Sequences load, slot scan, tick decision, release catch-up and output.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_command,
    input  wire logic          i_out_busy,
    input  wire rms_pkg::t_stat i_stat,
    output logic               o_in_stall,
    output rms_pkg::t_ctrl     o_ctrl
);
    import rms_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_valid) begin
                    if (i_command == CMD_LOAD) begin
                        o_ctrl.load = 1'b1;
                        n_state     = ST_OUT;
                    end else begin
                        o_ctrl.scan_clr = 1'b1;
                        n_state         = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_done) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_ctrl.decide = 1'b1;
                n_state       = ST_CATCHUP;
            end
            ST_CATCHUP: begin
                if (i_stat.need_catchup) o_ctrl.catchup = 1'b1;
                else                     n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_busy) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // only one datapath command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_ctrl)) else $error("multiple datapath commands");
    a_scan_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_stat.scan_done) |=> r_state == ST_DECIDE)
        else $error("scan did not lead to decide");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> r_state == ST_IDLE) else $error("accept outside idle");

endmodule

`default_nettype wire

### src/rms_dp.sv
// ----------------------------------------------------------------------------
// rms_dp: scheduler datapath
// Task table, serial best-ready scan, tick work and release catch-up.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rms_pkg::t_ctrl                i_ctrl,
    input  wire logic                          i_switch_overhead,
    input  wire logic [2:0]                    i_task_index,
    input  wire logic [15:0]                   i_task_period,
    input  wire logic [15:0]                   i_exec_time,
    input  wire logic [15:0]                   i_job_count,
    output rms_pkg::t_stat                     o_stat,
    output logic [2:0]                         o_event,
    output logic [2:0]                         o_running,
    output logic [31:0]                        o_now,
    output logic [15:0]                        o_missed,
    output logic                               o_all_done
);
    import rms_pkg::*;

    typedef logic [TIME_BITS-1:0] t_time;

    logic [15:0]  r_period [MAX_TASKS];
    logic [15:0]  r_exec   [MAX_TASKS];
    logic [15:0]  r_remain [MAX_TASKS];
    t_time        r_rel    [MAX_TASKS];
    t_time        r_dl     [MAX_TASKS];
    logic [15:0]  r_jobs   [MAX_TASKS];
    logic         r_late   [MAX_TASKS];
    t_time        r_now;
    logic         r_run_v;
    logic [IDX_W-1:0] r_run_idx;
    logic [15:0]  r_miss;
    t_event       r_ev;

    // scan registers
    logic [SCAN_W-1:0] r_scan;
    logic              r_best_v;
    logic [IDX_W-1:0]  r_best;

    // catch-up registers: serial remainder of the release lag by the period
    logic             r_cu;
    logic [IDX_W-1:0] r_cu_idx;
    t_time            r_cu_d;
    logic [15:0]      r_cu_rem;
    logic [CU_W-1:0]  r_cu_cnt;

    // output registers
    logic [2:0]  r_o_ev;
    logic [2:0]  r_o_run;
    logic [31:0] r_o_now;
    logic [15:0] r_o_miss;
    logic        r_o_done;

    logic [IDX_W-1:0] scan_idx;
    logic             scan_ready;
    logic             load_hit;
    logic [IDX_W-1:0] load_idx;

    assign scan_idx   = r_scan[IDX_W-1:0];
    assign scan_ready = (r_jobs[scan_idx] != 16'd0) && (r_rel[scan_idx] <= r_now);
    assign load_idx   = i_task_index[IDX_W-1:0];
    assign load_hit   = ({1'b0, i_task_index} < 4'(MAX_TASKS));

    assign o_stat.scan_done    = (r_scan == SCAN_W'(MAX_TASKS - 1));
    assign o_stat.need_catchup = r_cu;

    // tick decision, combinational view of one work step
    logic             d_run_v;
    logic [IDX_W-1:0] d_run_idx;
    logic             d_work;
    t_time            d_now;
    t_event           d_ev;
    logic             d_preempt;

    t_time            w_now1, w_now2, w_rel, w_dl;
    logic             w_done, w_late;
    logic [15:0]      w_per;

    // catch-up step: restoring remainder, one lag bit per cycle
    logic [15:0]      cu_per;
    logic [16:0]      cu_shift, cu_sub;
    logic [15:0]      cu_rem_n;
    logic             cu_last;
    t_time            cu_rel;

    assign cu_per   = r_period[r_cu_idx];
    assign cu_shift = {r_cu_rem, r_cu_d[TIME_BITS-1]};
    assign cu_sub   = cu_shift - {1'b0, cu_per};
    assign cu_rem_n = (cu_shift >= {1'b0, cu_per}) ? cu_sub[15:0] : cu_shift[15:0];
    assign cu_last  = (r_cu_cnt == CU_W'(TIME_BITS - 1));
    // release lands on the first period boundary not before now
    assign cu_rel   = r_now + t_time'((cu_rem_n != 16'd0) ? cu_per - cu_rem_n : 16'd0);

    always_comb begin
        d_run_v   = r_run_v;
        d_run_idx = r_run_idx;
        d_work    = 1'b0;
        d_now     = r_now;
        d_ev      = EV_RUNNING;
        d_preempt = 1'b0;
        if (!r_run_v) begin
            if (!r_best_v) begin
                d_now = r_now + t_time'(1);
                d_ev  = EV_IDLE;
            end else begin
                d_run_v   = 1'b1;
                d_run_idx = r_best;
                d_work    = 1'b1;
            end
        end else if (r_best_v && (r_period[r_best] < r_period[r_run_idx])) begin
            d_run_idx = r_best;
            d_preempt = 1'b1;
            d_ev      = EV_PREEMPT;
            if (i_switch_overhead) d_now = r_now + t_time'(1);
            else                   d_work = 1'b1;
        end else begin
            d_work = 1'b1;
        end
        // work step on the chosen slot
        w_per  = r_period[d_run_idx];
        w_now1 = r_now + t_time'(1);
        w_done = (r_remain[d_run_idx] <= 16'd1);
        w_late = (r_dl[d_run_idx] < w_now1);
        w_now2 = i_switch_overhead ? w_now1 + t_time'(1) : w_now1;
        w_rel  = r_rel[d_run_idx] + t_time'(w_per);
        w_dl   = w_rel + t_time'(w_per);
        if (d_work) begin
            if (w_done) begin
                d_now = w_now2;
                d_ev  = w_late ? EV_LATE : EV_DONE;
            end else begin
                d_now = w_now1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_period[i] <= '0;
                r_exec[i]   <= '0;
                r_remain[i] <= '0;
                r_rel[i]    <= '0;
                r_dl[i]     <= '0;
                r_jobs[i]   <= '0;
                r_late[i]   <= 1'b0;
            end
            r_now     <= '0;
            r_run_v   <= 1'b0;
            r_run_idx <= '0;
            r_miss    <= '0;
            r_ev      <= EV_IDLE;
            r_scan    <= '0;
            r_best_v  <= 1'b0;
            r_best    <= '0;
            r_cu      <= 1'b0;
            r_cu_idx  <= '0;
            r_cu_d    <= '0;
            r_cu_rem  <= '0;
            r_cu_cnt  <= '0;
        end else begin
            // load one slot
            if (i_ctrl.load) begin
                if (load_hit) begin
                    r_period[load_idx] <= i_task_period;
                    r_exec[load_idx]   <= i_exec_time;
                    r_remain[load_idx] <= i_exec_time;
                    r_rel[load_idx]    <= '0;
                    r_dl[load_idx]     <= t_time'(i_task_period);
                    r_jobs[load_idx]   <= i_job_count;
                    r_late[load_idx]   <= 1'b0;
                    if (r_run_v && r_run_idx == load_idx) r_run_v <= 1'b0;
                end
                r_ev <= EV_LOAD;
            end
            // serial scan, one slot per cycle
            if (i_ctrl.scan_clr) begin
                r_scan   <= '0;
                r_best_v <= 1'b0;
            end
            if (i_ctrl.scan_step) begin
                if (scan_ready &&
                    (!r_best_v || r_period[scan_idx] < r_period[r_best])) begin
                    r_best_v <= 1'b1;
                    r_best   <= scan_idx;
                end
                if (!o_stat.scan_done) r_scan <= r_scan + SCAN_W'(1);
            end
            // tick decision
            if (i_ctrl.decide) begin
                r_run_idx <= d_run_idx;
                r_now     <= d_now;
                r_ev      <= d_ev;
                if (d_work && w_done) begin
                    if (w_late && r_miss != 16'hFFFF) r_miss <= r_miss + 16'd1;
                    r_rel[d_run_idx]    <= w_rel;
                    r_dl[d_run_idx]     <= w_dl;
                    r_remain[d_run_idx] <= r_exec[d_run_idx];
                    if (r_jobs[d_run_idx] != 16'd0)
                        r_jobs[d_run_idx] <= r_jobs[d_run_idx] - 16'd1;
                    r_late[d_run_idx]   <= w_late;
                    r_run_v             <= 1'b0;
                    r_cu                <= w_late && (w_per != 16'd0) && (w_rel < w_now2);
                    r_cu_idx            <= d_run_idx;
                    r_cu_d              <= w_now2 - w_rel;
                    r_cu_rem            <= '0;
                    r_cu_cnt            <= '0;
                end else begin
                    r_run_v <= d_run_v;
                    r_cu    <= 1'b0;
                    if (d_work) r_remain[d_run_idx] <= r_remain[d_run_idx] - 16'd1;
                end
            end
            // catch-up: lag mod period, one lag bit per step, then move release
            if (i_ctrl.catchup) begin
                r_cu_d   <= {r_cu_d[TIME_BITS-2:0], 1'b0};
                r_cu_rem <= cu_rem_n;
                r_cu_cnt <= r_cu_cnt + CU_W'(1);
                if (cu_last) begin
                    r_cu            <= 1'b0;
                    r_rel[r_cu_idx] <= cu_rel;
                    r_dl[r_cu_idx]  <= cu_rel + t_time'(cu_per);
                end
            end
        end
    end

    // all-done reduction over the table
    logic any_jobs;
    always_comb begin
        any_jobs = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++)
            if (r_jobs[i] != 16'd0) any_jobs = 1'b1;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_o_ev   <= r_ev;
            r_o_run  <= r_run_v ? 3'(r_run_idx) : 3'd0;
            r_o_now  <= r_now[31:0];
            r_o_miss <= r_miss;
            r_o_done <= !any_jobs;
        end
    end

    assign o_event    = r_o_ev;
    assign o_running  = r_o_run;
    assign o_now      = r_o_now;
    assign o_missed   = r_o_miss;
    assign o_all_done = r_o_done;

    a_cu_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.catchup |-> r_cu) else $error("catch-up without late job");
    a_miss_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_miss >= $past(r_miss)) else $error("miss counter decreased");
    a_preempt_overhead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.decide && d_preempt && i_switch_overhead) |=> r_run_v)
        else $error("preempt with overhead lost running task");

endmodule

`default_nettype wire

### src/rate_monotonic_task_scheduler_unit.sv
// Latency: a load result passes through the OUT state into the output
// register; a tick result through SCAN (one slot per step), DECIDE, CATCHUP
// and OUT, with serial release catch-up steps in CATCHUP after a late job whose next release already lies in the past.
// Throughput: one item at a time; the next item is accepted only after the
// result is registered, so the serial slot scan limits the tick rate, and a
// stalled result holds off the next item.
// Reset (synchronous, active low) clears the task table, time, miss count
// and running slot; switch_overhead resets to 1.
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler_unit: preemptive rate-monotonic scheduler
// Top level: handshakes, configuration register, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_monotonic_task_scheduler_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_command,
    input  wire logic [2:0]  i_task_index,
    input  wire logic [15:0] i_task_period,
    input  wire logic [15:0] i_exec_time,
    input  wire logic [15:0] i_job_count,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_event_res,
    output logic [2:0]       o_running_task,
    output logic [31:0]      o_now,
    output logic [15:0]      o_missed_total,
    output logic             o_all_done
);
    import rms_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  r_sw;
    logic  r_out_v;
    logic  out_busy;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_sw <= 1'b1;
        else if (i_cfg_valid) r_sw <= i_cfg_data;
    end

    // output valid
    assign out_busy = r_out_v && i_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_out_v <= 1'b0;
        else if (ctrl.out_load) r_out_v <= 1'b1;
        else if (!i_stall)     r_out_v <= 1'b0;
    end
    assign o_valid = r_out_v;

    rms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_command  (i_command),
        .i_out_busy (out_busy),
        .i_stat     (stat),
        .o_in_stall (o_stall),
        .o_ctrl     (ctrl)
    );

    rms_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .i_switch_overhead (r_sw),
        .i_task_index      (i_task_index),
        .i_task_period     (i_task_period),
        .i_exec_time       (i_exec_time),
        .i_job_count       (i_job_count),
        .o_stat            (stat),
        .o_event           (o_event_res),
        .o_running         (o_running_task),
        .o_now             (o_now),
        .o_missed          (o_missed_total),
        .o_all_done        (o_all_done)
    );

endmodule

`default_nettype wire

### dv/rate_monotonic_task_scheduler_unit_tb.sv
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler_unit_tb: self-checking scheduler testbench
// Drives load and tick items with bursty input and random output stalls,
// predicts each result with a behavioral scheduler model and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_monotonic_task_scheduler_unit_tb;
    import rms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1030;
    localparam int N_DIRECTED = 14;

    // result record
    typedef struct packed {
        t_event      ev;
        logic [2:0]  slot;
        logic [31:0] now;
        logic [15:0] missed;
        logic        done;
    } t_sched_res;

    // input item
    typedef struct packed {
        logic        cmd;
        logic [2:0]  idx;
        logic [15:0] period;
        logic [15:0] exec;
        logic [15:0] jobs;
    } t_sched_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = 1'b0;
    logic [2:0]  i_task_index = '0;
    logic [15:0] i_task_period = '0;
    logic [15:0] i_exec_time = '0;
    logic [15:0] i_job_count = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_event_res;
    logic [2:0]  o_running_task;
    logic [31:0] o_now;
    logic [15:0] o_missed_total;
    logic        o_all_done;

    rate_monotonic_task_scheduler_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_task_index   (i_task_index),
        .i_task_period  (i_task_period),
        .i_exec_time    (i_exec_time),
        .i_job_count    (i_job_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_res    (o_event_res),
        .o_running_task (o_running_task),
        .o_now          (o_now),
        .o_missed_total (o_missed_total),
        .o_all_done     (o_all_done)
    );

    always #5 i_clk = ~i_clk;

    // scheduler state mirror
    logic [15:0] m_period [MAX_TASKS];
    logic [15:0] m_exec   [MAX_TASKS];
    logic [15:0] m_remain [MAX_TASKS];
    logic [31:0] m_release[MAX_TASKS];
    logic [31:0] m_deadline[MAX_TASKS];
    logic [15:0] m_jobs   [MAX_TASKS];
    logic [31:0] m_now;
    logic        m_run_valid;
    logic [2:0]  m_run_slot;
    logic [15:0] m_missed;
    logic        m_switch_cost;

    t_sched_res  pending_results[$];
    int          n_mismatch = 0;
    int          n_results = 0;
    int          n_late = 0;
    int          n_preempt = 0;

    // directed rows: item, typed-in expectation, flag saying whether it is used
    t_sched_item dir_item[N_DIRECTED];
    t_sched_res  dir_res[N_DIRECTED];
    logic        dir_typed[N_DIRECTED];

    function automatic void sched_reset();
        for (int i = 0; i < MAX_TASKS; i++) begin
            m_period[i] = '0;
            m_exec[i] = '0;
            m_remain[i] = '0;
            m_release[i] = '0;
            m_deadline[i] = '0;
            m_jobs[i] = '0;
        end
        m_now = '0;
        m_run_valid = 1'b0;
        m_run_slot = '0;
        m_missed = '0;
        m_switch_cost = 1'b1;
    endfunction

    function automatic int sched_best_ready();
        int best;
        best = -1;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (m_jobs[i] != 0 && m_release[i] <= m_now) begin
                if (best < 0 || m_period[i] < m_period[best])
                    best = i;
            end
        end
        return best;
    endfunction

    // one tick of work on the running slot; returns completion event or running
    function automatic t_event sched_work();
        logic [2:0]  s;
        logic        late;
        logic [63:0] per, rel, d, n;
        s = m_run_slot;
        m_now = m_now + 32'd1;
        if (m_remain[s] > 1) begin
            m_remain[s] = m_remain[s] - 16'd1;
            return EV_RUNNING;
        end
        late = m_deadline[s] < m_now;
        if (late && m_missed != 16'hFFFF)
            m_missed = m_missed + 16'd1;
        if (m_switch_cost)
            m_now = m_now + 32'd1;
        per = 64'(m_period[s]);
        rel = 64'((m_release[s] + 32'(per)));
        if (late && per != 0 && rel < 64'(m_now)) begin
            d = 64'(m_now) - rel;
            n = d / per + ((d % per) != 0 ? 64'd1 : 64'd0);
            rel = (rel + n * per) & 64'hFFFF_FFFF;
        end
        m_release[s] = rel[31:0];
        m_deadline[s] = rel[31:0] + per[31:0];
        m_remain[s] = m_exec[s];
        if (m_jobs[s] != 0)
            m_jobs[s] = m_jobs[s] - 16'd1;
        m_run_valid = 1'b0;
        return late ? EV_LATE : EV_DONE;
    endfunction

    function automatic t_sched_res sched_step(t_sched_item it);
        t_sched_res r;
        t_event     ev;
        int         b;
        if (it.cmd == CMD_LOAD) begin
            m_period[it.idx] = it.period;
            m_exec[it.idx] = it.exec;
            m_remain[it.idx] = it.exec;
            m_release[it.idx] = '0;
            m_deadline[it.idx] = 32'(it.period);
            m_jobs[it.idx] = it.jobs;
            if (m_run_valid && m_run_slot == it.idx)
                m_run_valid = 1'b0;
            ev = EV_LOAD;
        end else begin
            b = sched_best_ready();
            if (!m_run_valid) begin
                if (b < 0) begin
                    m_now = m_now + 32'd1;
                    ev = EV_IDLE;
                end else begin
                    m_run_valid = 1'b1;
                    m_run_slot = 3'(b);
                    ev = sched_work();
                end
            end else if (b >= 0 && m_period[b] < m_period[m_run_slot]) begin
                m_run_slot = 3'(b);
                if (m_switch_cost) begin
                    m_now = m_now + 32'd1;
                    ev = EV_PREEMPT;
                end else begin
                    ev = sched_work();
                    if (ev == EV_RUNNING)
                        ev = EV_PREEMPT;
                end
            end else begin
                ev = sched_work();
            end
        end
        r.ev = ev;
        r.slot = m_run_valid ? m_run_slot : 3'd0;
        r.now = m_now;
        r.missed = m_missed;
        r.done = 1'b1;
        for (int i = 0; i < MAX_TASKS; i++)
            if (m_jobs[i] != 0)
                r.done = 1'b0;
        return r;
    endfunction

    // send one item through the input channel; a new burst may begin with a random gap
    int burst_left = 0;
    task automatic send_item(t_sched_item it, logic typed, t_sched_res want);
        t_sched_res p;
        int         gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_command <= it.cmd;
        i_task_index <= it.idx;
        i_task_period <= it.period;
        i_exec_time <= it.exec;
        i_job_count <= it.jobs;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        p = sched_step(it);
        if (typed && p != want)
            $display("directed row disagrees with predictor: %h vs %h", want, p);
        if (typed)
            p = want;
        pending_results = {pending_results, p};
    endtask

    // output stall pattern: runs of free cycles and runs of random stalls
    int stall_run = 0;
    logic stall_mode = 1'b0;
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 2) == 0;
            stall_run <= $urandom_range(1, 12);
        end else begin
            stall_run <= stall_run - 1;
        end
        i_stall <= (stall_run == 0) ? 1'b0 : (stall_mode & 1'($urandom_range(0, 1)));
    end

    // result checker
    always @(posedge i_clk) begin
        t_sched_res got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{t_event'(o_event_res), o_running_task, o_now, o_missed_total,
                    o_all_done};
            n_results++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result transfer: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got.ev == EV_LATE) n_late++;
                if (got.ev == EV_PREEMPT) n_preempt++;
                if (got != want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch: exp ev=%0d slot=%0d now=%0d miss=%0d ",
                                  "done=%0d, got ev=%0d slot=%0d now=%0d miss=%0d ",
                                  "done=%0d"},
                                 want.ev, want.slot, want.now, want.missed, want.done,
                                 got.ev, got.slot, got.now, got.missed, got.done);
                end
            end
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4 * MAX_TASKS + 20) @(posedge i_clk);
    endtask

    task automatic write_switch_cost(logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        m_switch_cost = v;
    endtask

    function automatic t_sched_item mk(logic c, int x, int p, int e, int j);
        t_sched_item it;
        it.cmd = c;
        it.idx = 3'(x);
        it.period = 16'(p);
        it.exec = 16'(e);
        it.jobs = 16'(j);
        return it;
    endfunction

    // random item: mostly ticks over small task sets, some loads
    function automatic t_sched_item rand_item();
        t_sched_item it;
        int r;
        r = $urandom_range(0, 99);
        it = {1'b1, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        if (r < 14) begin
            it.cmd = CMD_LOAD;
            if ($urandom_range(0, 9) != 0) begin
                it.period = 16'($urandom_range(0, 40));
                it.exec = 16'($urandom_range(0, 12));
                it.jobs = 16'($urandom_range(0, 6));
            end
        end
        return it;
    endfunction

    initial begin
        t_sched_res e;
        sched_reset();
        // directed table
        dir_item[0]  = mk(CMD_TICK, 0, 0, 0, 0);
        dir_item[1]  = mk(CMD_LOAD, 7, 65535, 65535, 65535);
        dir_item[2]  = mk(CMD_LOAD, 7, 0, 0, 0);
        dir_item[3]  = mk(CMD_LOAD, 0, 20, 3, 2);
        dir_item[4]  = mk(CMD_TICK, 0, 0, 0, 0);
        dir_item[5]  = mk(CMD_LOAD, 1, 5, 1, 1);
        dir_item[6]  = mk(CMD_TICK, 0, 0, 0, 0);
        dir_item[7]  = mk(CMD_TICK, 0, 0, 0, 0);
        dir_item[8]  = mk(CMD_LOAD, 2, 1, 4, 1);
        dir_item[9]  = mk(CMD_TICK, 0, 0, 0, 0);
        dir_item[10] = mk(CMD_LOAD, 0, 2, 0, 1);
        dir_item[11] = mk(CMD_LOAD, 3, 20, 5, 1);
        dir_item[12] = mk(CMD_TICK, 0, 0, 0, 0);
        dir_item[13] = mk(CMD_TICK, 0, 0, 0, 0);
        for (int k = 0; k < N_DIRECTED; k++)
            dir_typed[k] = 1'b0;
        // after reset: idle tick, then load done at the field extremes
        dir_res[0] = '{EV_IDLE, 3'd0, 32'd1, 16'd0, 1'b1};
        dir_res[1] = '{EV_LOAD, 3'd0, 32'd1, 16'd0, 1'b0};
        dir_res[2] = '{EV_LOAD, 3'd0, 32'd1, 16'd0, 1'b1};
        dir_typed[0] = 1'b1;
        dir_typed[1] = 1'b1;
        dir_typed[2] = 1'b1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_switch_cost(1'b1);
        for (int k = 0; k < N_DIRECTED; k++)
            send_item(dir_item[k], dir_typed[k], dir_res[k]);
        wait_drained();

        // random phases alternating switch cost
        for (int ph = 0; ph < 6; ph++) begin
            write_switch_cost(ph[0]);
            for (int k = 0; k < N_RANDOM / 6; k++)
                send_item(rand_item(), 1'b0, e);
            wait_drained();
        end

        $display("covered %0d results, %0d late completions, %0d preemptions",
                 n_results, n_late, n_preempt);
        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
